/* hdl/color_fade_hold_sequencer_assert.svh */
// Assertion macros shared by the color fade hold sequencer modules
`ifndef COLOR_FADE_HOLD_SEQUENCER_ASSERT_SVH
`define COLOR_FADE_HOLD_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFHS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfhs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CFHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfhs assertion failed");

`endif

/* hdl/cfhs_pkg.sv */
// Shared types, constants and arithmetic helpers of the color fade hold sequencer
`default_nettype none

package cfhs_pkg;

   localparam int unsigned MAX_TARGETS_DEFAULT = 8;
   localparam int unsigned CHANNELS            = 3;
   localparam int unsigned CHAN_W              = $clog2(CHANNELS);
   localparam int unsigned COLOR_W             = 16;
   localparam int unsigned FRAC_EXTRA          = 16;
   localparam int unsigned ACC_W               = COLOR_W + FRAC_EXTRA;
   localparam int unsigned LEN_W               = 16;
   localparam int unsigned COUNT_W             = 4;
   localparam int unsigned ENTRY_IDX_W         = 3;
   localparam int unsigned STAGE_OUT_W         = 4;
   localparam int unsigned DIV_BITS_PER_STEP   = 2;

   localparam int unsigned REQ_TDATA_W = 88;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET = 4'd2;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic CSR_TARGET_COUNT = 1'b0;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOOKUP,
      ST_TARGET,
      ST_SOURCE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ADD,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      command;
      logic [ENTRY_IDX_W-1:0]    entry_index;
      logic signed [COLOR_W-1:0] entry_l;
      logic signed [COLOR_W-1:0] entry_a;
      logic signed [COLOR_W-1:0] entry_b;
      logic [LEN_W-1:0]          fade_length;
      logic [LEN_W-1:0]          hold_length;
   } request_type;

   typedef struct packed {
      logic signed [COLOR_W-1:0] color_l;
      logic signed [COLOR_W-1:0] color_a;
      logic signed [COLOR_W-1:0] color_b;
      logic                      color_changed;
      logic [STAGE_OUT_W-1:0]    stage_now;
   } result_type;

   typedef struct packed {
      logic [CHANNELS-1:0][COLOR_W-1:0] color;
      logic [LEN_W-1:0]                 fade_length;
      logic [LEN_W-1:0]                 hold_length;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_rsp_type;

   // Two's complement add, clipped at the 32-bit bounds.
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] sum;
      sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = sum[ACC_W-1:0];
      end
   endfunction

   // Apply the sign to an unsigned quotient and clip to the signed range.
   function automatic logic [ACC_W-1:0] clamp_step(input logic [ACC_W-1:0] mag,
                                                   input logic             neg);
      if (neg) begin
         clamp_step = (mag > ACC_MIN) ? ACC_MIN : ({ACC_W{1'b0}} - mag);
      end else begin
         clamp_step = mag[ACC_W-1] ? ACC_MAX : mag;
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/cfhs_divider.sv */
// Radix-4 restoring divider shared by the three color channels
`default_nettype none

module cfhs_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfhs_pkg::div_req_type div_req,
   output cfhs_pkg::div_rsp_type      div_rsp
);

   `include "color_fade_hold_sequencer_assert.svh"

   localparam int unsigned ACC_W   = cfhs_pkg::ACC_W;
   localparam int unsigned LEN_W   = cfhs_pkg::LEN_W;
   localparam int unsigned BPS     = cfhs_pkg::DIV_BITS_PER_STEP;
   localparam int unsigned STEPS   = ACC_W / BPS;
   localparam int unsigned STEP_CW = $clog2(STEPS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_CW-1:0] count_ff, count_in;
   logic [ACC_W-1:0]   work_ff, work_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   divisor_ff, divisor_in;

   logic [ACC_W-1:0]   step_work;
   logic [LEN_W-1:0]   step_rem;
   logic [LEN_W:0]     trial;

   always_comb begin
      // shift in dividend bits, subtract where it fits, shift in quotient bits
      step_work = work_ff;
      step_rem  = rem_ff;
      trial     = '0;
      for (int i = 0; i < BPS; i++) begin
         trial     = {step_rem, step_work[ACC_W-1]};
         step_work = {step_work[ACC_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial        = trial - {1'b0, divisor_ff};
            step_work[0] = 1'b1;
         end
         step_rem = trial[LEN_W-1:0];
      end

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = STEP_CW'(STEPS);
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         work_in  = step_work;
         rem_in   = step_rem;
         count_in = count_ff - STEP_CW'(1);
         if (count_ff == STEP_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

   `CFHS_ASSERT_NEXT(a_div_start_busy, clock, reset, div_req.start, busy_ff)
   `CFHS_ASSERT_SAME(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `CFHS_ASSERT_SAME(a_div_rem_below, clock, reset, done_ff && (divisor_ff != '0), rem_ff < divisor_ff)

endmodule

`default_nettype wire

/* hdl/cfhs_core.sv */
// Stage sequencer, target table and color accumulators of the fade hold sequencer
`default_nettype none

module cfhs_core #(
   parameter int unsigned MAX_TARGETS = cfhs_pkg::MAX_TARGETS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [cfhs_pkg::COUNT_W-1:0]  count_cfg,
   input  wire logic                          req_valid,
   input  wire cfhs_pkg::request_type         req,
   output logic                               req_ready,
   output logic                               rsp_valid,
   output cfhs_pkg::result_type               rsp,
   input  wire logic                          rsp_take
);

   `include "color_fade_hold_sequencer_assert.svh"

   localparam int unsigned CHANNELS = cfhs_pkg::CHANNELS;
   localparam int unsigned CHAN_W   = cfhs_pkg::CHAN_W;
   localparam int unsigned COLOR_W  = cfhs_pkg::COLOR_W;
   localparam int unsigned FRAC_X   = cfhs_pkg::FRAC_EXTRA;
   localparam int unsigned ACC_W    = cfhs_pkg::ACC_W;
   localparam int unsigned LEN_W    = cfhs_pkg::LEN_W;
   localparam int unsigned SOUT_W   = cfhs_pkg::STAGE_OUT_W;
   localparam int unsigned STG_W    = $clog2(2 * MAX_TARGETS);
   localparam int unsigned IDX_W    = STG_W - 1;
   localparam int unsigned CNT_W    = $clog2(MAX_TARGETS + 1);
   localparam int unsigned CMP_W    = STG_W + 1;

   cfhs_pkg::state_type               state_ff, state_in;
   cfhs_pkg::request_type             req_ff, req_in;
   logic [STG_W-1:0]                  stage_ff, stage_in;
   logic [LEN_W-1:0]                  frame_ff, frame_in;
   logic [CHANNELS-1:0][ACC_W-1:0]    acc_ff, acc_in;
   logic [CHANNELS-1:0][ACC_W-1:0]    step_ff, step_in;
   logic [CHANNELS-1:0][COLOR_W-1:0]  tgt_ff, tgt_in;
   logic [LEN_W-1:0]                  len_ff, len_in;
   logic                              changed_ff, changed_in;
   logic [CHAN_W-1:0]                 chan_ff, chan_in;
   logic                              neg_ff, neg_in;

   cfhs_pkg::entry_type               mem_ff [MAX_TARGETS];
   cfhs_pkg::entry_type               rd_data_ff;
   cfhs_pkg::entry_type               mem_wdata;
   logic                              mem_we;
   logic                              rd_en;
   logic [IDX_W-1:0]                  rd_addr;

   cfhs_pkg::div_req_type             div_req;
   cfhs_pkg::div_rsp_type             div_rsp;

   logic [CNT_W-1:0]                  count_eff;
   logic [CMP_W-1:0]                  two_count;
   logic [CMP_W-1:0]                  stage_inc;
   logic                              stage_stale;
   logic [IDX_W-1:0]                  target_idx;
   logic [IDX_W-1:0]                  source_idx;
   logic                              write_in_range;
   logic                              write_is_last;
   logic                              last_frame;
   logic [COLOR_W:0]                  diff;
   logic [COLOR_W:0]                  diff_abs;

   // clip the configured count into 1..MAX_TARGETS
   always_comb begin
      if (count_cfg == '0) begin
         count_eff = CNT_W'(1);
      end else if (32'(count_cfg) > 32'(MAX_TARGETS)) begin
         count_eff = CNT_W'(MAX_TARGETS);
      end else begin
         count_eff = CNT_W'(count_cfg);
      end
   end

   assign two_count   = CMP_W'({count_eff, 1'b0});
   assign stage_inc   = {1'b0, stage_ff} + CMP_W'(1);
   assign stage_stale = ({1'b0, stage_ff} >= two_count);
   assign target_idx  = stage_ff[STG_W-1:1];
   assign source_idx  = (target_idx == '0) ? IDX_W'(count_eff - CNT_W'(1))
                                           : target_idx - IDX_W'(1);

   assign write_in_range = (32'(req_ff.entry_index) < 32'(MAX_TARGETS));
   assign write_is_last  = ((32'(req_ff.entry_index) + 32'd1) == 32'(count_eff));
   assign last_frame     = (len_ff == '0) ||
                           (({1'b0, frame_ff} + (LEN_W+1)'(1)) == {1'b0, len_ff});

   // channel difference and its magnitude for the divider
   assign diff     = {tgt_ff[chan_ff][COLOR_W-1], tgt_ff[chan_ff]} -
                     {rd_data_ff.color[chan_ff][COLOR_W-1], rd_data_ff.color[chan_ff]};
   assign diff_abs = diff[COLOR_W] ? ((COLOR_W+1)'(0) - diff) : diff;

   assign mem_wdata.color[0]   = req_ff.entry_l;
   assign mem_wdata.color[1]   = req_ff.entry_a;
   assign mem_wdata.color[2]   = req_ff.entry_b;
   assign mem_wdata.fade_length = req_ff.fade_length;
   assign mem_wdata.hold_length = req_ff.hold_length;

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      stage_in   = stage_ff;
      frame_in   = frame_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      tgt_in     = tgt_ff;
      len_in     = len_ff;
      changed_in = changed_ff;
      chan_in    = chan_ff;
      neg_in     = neg_ff;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = target_idx;
      div_req.start    = 1'b0;
      div_req.dividend = {diff_abs[COLOR_W-1:0], {FRAC_X{1'b0}}};
      div_req.divisor  = len_ff;

      unique case (state_ff)
         cfhs_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req;
               if (req.command == cfhs_pkg::CMD_WRITE) begin
                  state_in = cfhs_pkg::ST_WRITE;
               end else begin
                  // restart when the count shrank below the current stage
                  if (stage_stale) begin
                     stage_in = '0;
                     frame_in = '0;
                  end
                  state_in = cfhs_pkg::ST_LOOKUP;
               end
            end
         end

         cfhs_pkg::ST_WRITE: begin
            changed_in = 1'b0;
            if (write_in_range) begin
               mem_we = 1'b1;
               if (write_is_last) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     acc_in[c] = {mem_wdata.color[c], {FRAC_X{1'b0}}};
                  end
                  stage_in = '0;
                  frame_in = '0;
               end
            end
            state_in = cfhs_pkg::ST_DONE;
         end

         cfhs_pkg::ST_LOOKUP: begin
            rd_en    = 1'b1;
            rd_addr  = target_idx;
            state_in = cfhs_pkg::ST_TARGET;
         end

         cfhs_pkg::ST_TARGET: begin
            if (stage_ff[0]) begin
               // hold: snap to the exact target on the first frame
               if (frame_ff == '0) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     acc_in[c] = {rd_data_ff.color[c], {FRAC_X{1'b0}}};
                  end
               end
               len_in     = rd_data_ff.hold_length;
               changed_in = (frame_ff == '0);
               state_in   = cfhs_pkg::ST_FINISH;
            end else begin
               len_in     = rd_data_ff.fade_length;
               changed_in = 1'b1;
               chan_in    = '0;
               if (frame_ff == '0) begin
                  tgt_in   = rd_data_ff.color;
                  rd_en    = 1'b1;
                  rd_addr  = source_idx;
                  state_in = cfhs_pkg::ST_SOURCE;
               end else begin
                  state_in = cfhs_pkg::ST_ADD;
               end
            end
         end

         cfhs_pkg::ST_SOURCE: begin
            chan_in = '0;
            if (len_ff == '0) begin
               step_in  = '0;
               state_in = cfhs_pkg::ST_ADD;
            end else begin
               state_in = cfhs_pkg::ST_DIV_GO;
            end
         end

         cfhs_pkg::ST_DIV_GO: begin
            div_req.start = 1'b1;
            neg_in        = diff[COLOR_W];
            state_in      = cfhs_pkg::ST_DIV_WAIT;
         end

         cfhs_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               step_in[chan_ff] = cfhs_pkg::clamp_step(div_rsp.quotient, neg_ff);
               if (chan_ff == CHAN_W'(CHANNELS - 1)) begin
                  chan_in  = '0;
                  state_in = cfhs_pkg::ST_ADD;
               end else begin
                  chan_in  = chan_ff + CHAN_W'(1);
                  state_in = cfhs_pkg::ST_DIV_GO;
               end
            end
         end

         cfhs_pkg::ST_ADD: begin
            acc_in[chan_ff] = cfhs_pkg::sat_add(acc_ff[chan_ff], step_ff[chan_ff]);
            if (chan_ff == CHAN_W'(CHANNELS - 1)) begin
               chan_in  = '0;
               state_in = cfhs_pkg::ST_FINISH;
            end else begin
               chan_in = chan_ff + CHAN_W'(1);
            end
         end

         cfhs_pkg::ST_FINISH: begin
            if (last_frame) begin
               stage_in = (stage_inc == two_count) ? '0 : stage_inc[STG_W-1:0];
               frame_in = '0;
            end else begin
               frame_in = frame_ff + LEN_W'(1);
            end
            state_in = cfhs_pkg::ST_DONE;
         end

         cfhs_pkg::ST_DONE: begin
            if (rsp_take) begin
               state_in = cfhs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cfhs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cfhs_pkg::ST_IDLE;
         stage_ff   <= '0;
         frame_ff   <= '0;
         acc_ff     <= '0;
         step_ff    <= '0;
         changed_ff <= 1'b0;
         chan_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         stage_ff   <= stage_in;
         frame_ff   <= frame_in;
         acc_ff     <= acc_in;
         step_ff    <= step_in;
         changed_ff <= changed_in;
         chan_ff    <= chan_in;
      end
      req_ff <= req_in;
      tgt_ff <= tgt_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
   end

   // target table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[IDX_W'(req_ff.entry_index)] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   cfhs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready         = (state_ff == cfhs_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == cfhs_pkg::ST_DONE);
   assign rsp.color_l       = acc_ff[0][ACC_W-1:FRAC_X];
   assign rsp.color_a       = acc_ff[1][ACC_W-1:FRAC_X];
   assign rsp.color_b       = acc_ff[2][ACC_W-1:FRAC_X];
   assign rsp.color_changed = changed_ff;
   assign rsp.stage_now     = SOUT_W'(stage_ff);

   `CFHS_ASSERT_NEXT(a_core_result_held, clock, reset, rsp_valid && !rsp_take, rsp_valid && $stable(rsp))
   `CFHS_ASSERT_NEXT(a_core_div_started, clock, reset, state_ff == cfhs_pkg::ST_DIV_GO, div_rsp.busy)
   `CFHS_ASSERT_NEXT(a_core_write_quiet, clock, reset, state_ff == cfhs_pkg::ST_WRITE, (state_ff == cfhs_pkg::ST_DONE) && !changed_ff)

endmodule

`default_nettype wire

/* hdl/color_fade_hold_sequencer.sv */
// Top level of the color fade hold sequencer: stream ports, APB register, output register
// Sequence: a write beat passes WRITE then DONE; a hold tick LOOKUP, TARGET, FINISH, DONE;
//   a fade tick inside a stage adds ADD before FINISH; a tick that opens a fade stage of
//   nonzero length also runs three 16-step radix-4 divisions in turn in the shared divider.
// Throughput: one beat at a time; req_tready rises again in the cycle the result enters rsp.
// Reset (synchronous, active high): target count = 2, stage 0, frame 0, color and steps zero;
//   the target table is not cleared and holds garbage until written.
`default_nettype none

module color_fade_hold_sequencer #(
   parameter int unsigned MAX_TARGETS = cfhs_pkg::MAX_TARGETS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // entry_index, entry_l, entry_a, entry_b, fade_length, hold_length, zero pad
   input  wire logic [cfhs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command
   input  wire logic                               req_tuser,

   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // color_l, color_a, color_b, color_changed, stage_now, zero pad
   output logic [cfhs_pkg::RSP_TDATA_W-1:0]        rsp_tdata,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cfhs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [cfhs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cfhs_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   localparam int unsigned COUNT_W   = cfhs_pkg::COUNT_W;
   localparam int unsigned CSR_DW    = cfhs_pkg::CSR_DATA_W;
   localparam int unsigned CSR_AW    = cfhs_pkg::CSR_ADDR_W;
   localparam int unsigned RSP_DW    = cfhs_pkg::RSP_TDATA_W;
   localparam int unsigned RSP_USED  = $bits(cfhs_pkg::result_type);

   // ---------------------------------------------------------------- config
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               csr_write;
   logic               csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1] == cfhs_pkg::CSR_TARGET_COUNT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign count_in   = (csr_write && csr_hit) ? csr_pwdata[COUNT_W-1:0] : count_ff;
   assign csr_prdata = csr_hit ? CSR_DW'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= cfhs_pkg::TARGET_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------- request unpack
   cfhs_pkg::request_type core_req;

   assign core_req.command     = req_tuser;
   assign core_req.entry_index = req_tdata[2:0];
   assign core_req.entry_l     = req_tdata[18:3];
   assign core_req.entry_a     = req_tdata[34:19];
   assign core_req.entry_b     = req_tdata[50:35];
   assign core_req.fade_length = req_tdata[66:51];
   assign core_req.hold_length = req_tdata[82:67];

   // ---------------------------------------------------------------- core
   logic                 core_rsp_valid;
   logic                 core_rsp_take;
   cfhs_pkg::result_type core_rsp;

   cfhs_core #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .count_cfg (count_ff),
      .req_valid (req_tvalid),
      .req       (core_req),
      .req_ready (req_tready),
      .rsp_valid (core_rsp_valid),
      .rsp       (core_rsp),
      .rsp_take  (core_rsp_take)
   );

   // ---------------------------------------------------------------- output register
   // Hold the finished beat here so the core can go back for the next request.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_DW-1:0] rsp_packed;

   assign rsp_packed    = {{(RSP_DW-RSP_USED){1'b0}},
                           core_rsp.stage_now,
                           core_rsp.color_changed,
                           core_rsp.color_b,
                           core_rsp.color_a,
                           core_rsp.color_l};
   assign core_rsp_take = core_rsp_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_rsp_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_packed;
      end else if (rsp_tready) begin
         // drop the beat once the sink took it
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* test/tb_color_fade_hold_sequencer.sv */
// Self-checking testbench for the color fade hold sequencer: directed stages, then random traffic
module tb_color_fade_hold_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COLOR_W     = cfhs_pkg::COLOR_W;
   localparam int unsigned CHANNELS    = cfhs_pkg::CHANNELS;
   localparam int unsigned LEN_W       = cfhs_pkg::LEN_W;
   localparam int unsigned ACC_W       = cfhs_pkg::ACC_W;
   localparam int unsigned FRAC_EXTRA  = cfhs_pkg::FRAC_EXTRA;
   localparam int unsigned COUNT_W     = cfhs_pkg::COUNT_W;
   localparam int unsigned ENTRY_IDX_W = cfhs_pkg::ENTRY_IDX_W;
   localparam int unsigned STAGE_OUT_W = cfhs_pkg::STAGE_OUT_W;
   localparam int unsigned REQ_TDATA_W = cfhs_pkg::REQ_TDATA_W;
   localparam int unsigned RSP_TDATA_W = cfhs_pkg::RSP_TDATA_W;
   localparam int unsigned CSR_ADDR_W  = cfhs_pkg::CSR_ADDR_W;
   localparam int unsigned CSR_DATA_W  = cfhs_pkg::CSR_DATA_W;

   localparam int unsigned TABLE_DEPTH    = cfhs_pkg::MAX_TARGETS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT    = 800_000;
   localparam int unsigned PHASE_BEATS    = 110;
   localparam int unsigned RANDOM_PHASES  = 15;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES  = 100;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {cfhs_pkg::CSR_TARGET_COUNT, 2'b00};
   localparam longint ACC_HI = (longint'(1) <<< 31) - 1;
   localparam longint ACC_LO = -(longint'(1) <<< 31);

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = cfhs_pkg::CMD_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   color_fade_hold_sequencer #(
      .MAX_TARGETS(TABLE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the sequencer: tables, stage walk, Q16.16 accumulators and steps.
   // Table entries stay unknown until written; the stimulus loads all of them first.
   logic signed [COLOR_W-1:0] tgt_colors   [TABLE_DEPTH][CHANNELS];
   logic [LEN_W-1:0]          fade_len_tab [TABLE_DEPTH];
   logic [LEN_W-1:0]          hold_len_tab [TABLE_DEPTH];
   int unsigned               stage_idx = 0;
   int unsigned               frame_idx = 0;
   logic signed [ACC_W-1:0]   color_acc [CHANNELS] = '{default: '0};
   logic signed [ACC_W-1:0]   fade_step [CHANNELS] = '{default: '0};
   logic [COUNT_W-1:0]        count_setting = cfhs_pkg::TARGET_COUNT_RESET;

   cfhs_pkg::result_type expected_colors [$];
   int                   mismatch_count   = 0;
   int unsigned          holdoff_requests = 0;
   bit                   steady_flow      = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Effective target count: zero acts as one, anything past the table acts as the table size.
   function automatic int unsigned active_targets();
      if (count_setting == 0) return 1;
      if (count_setting > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(count_setting);
   endfunction

   function automatic logic signed [ACC_W-1:0] clip_acc(input longint v);
      if (v > ACC_HI) return ACC_HI[ACC_W-1:0];
      if (v < ACC_LO) return ACC_LO[ACC_W-1:0];
      return v[ACC_W-1:0];
   endfunction

   // Apply one beat to the shadow state and return the color the block must report.
   function automatic cfhs_pkg::result_type advance_sequencer(input cfhs_pkg::request_type r);
      int unsigned          cnt;
      int unsigned          tgt;
      int unsigned          src;
      int unsigned          len;
      int                   c;
      longint               num;
      longint               frames;
      logic                 changed;
      cfhs_pkg::result_type res;
      cnt = active_targets();
      if (r.command == cfhs_pkg::CMD_WRITE) begin
         tgt = 32'(r.entry_index);
         tgt_colors[tgt][0] = r.entry_l;
         tgt_colors[tgt][1] = r.entry_a;
         tgt_colors[tgt][2] = r.entry_b;
         fade_len_tab[tgt]  = r.fade_length;
         hold_len_tab[tgt]  = r.hold_length;
         // Loading the last entry of the cycle jumps to it and restarts the walk.
         if (tgt == cnt - 1) begin
            for (c = 0; c < CHANNELS; c++) begin
               color_acc[c] = {tgt_colors[tgt][c], {FRAC_EXTRA{1'b0}}};
            end
            stage_idx = 0;
            frame_idx = 0;
         end
         changed = 1'b0;
      end else begin
         // Stage left over from a larger count: restart the walk.
         if (stage_idx >= 2 * cnt) begin
            stage_idx = 0;
            frame_idx = 0;
         end
         tgt = stage_idx / 2;
         if (stage_idx % 2 == 1) begin
            if (frame_idx == 0) begin
               for (c = 0; c < CHANNELS; c++) begin
                  color_acc[c] = {tgt_colors[tgt][c], {FRAC_EXTRA{1'b0}}};
               end
            end
            len = 32'(hold_len_tab[tgt]);
         end else begin
            if (frame_idx == 0) begin
               src    = (tgt == 0) ? cnt - 1 : tgt - 1;
               frames = 64'(fade_len_tab[tgt]);
               for (c = 0; c < CHANNELS; c++) begin
                  if (frames == 0) begin
                     fade_step[c] = '0;
                  end else begin
                     num = (longint'(tgt_colors[tgt][c]) - longint'(tgt_colors[src][c]))
                           * 65536;
                     fade_step[c] = clip_acc(num / frames);
                  end
               end
            end
            len = 32'(fade_len_tab[tgt]);
            for (c = 0; c < CHANNELS; c++) begin
               color_acc[c] = clip_acc(longint'(color_acc[c]) + longint'(fade_step[c]));
            end
         end
         changed = (stage_idx % 2 == 0) || (frame_idx == 0);
         if (len == 0 || frame_idx == len - 1) begin
            stage_idx = (stage_idx + 1) % (2 * cnt);
            frame_idx = 0;
         end else begin
            frame_idx = (frame_idx + 1) & 16'hFFFF;
         end
      end
      res.color_l       = color_acc[0][ACC_W-1:FRAC_EXTRA];
      res.color_a       = color_acc[1][ACC_W-1:FRAC_EXTRA];
      res.color_b       = color_acc[2][ACC_W-1:FRAC_EXTRA];
      res.color_changed = changed;
      res.stage_now     = stage_idx[STAGE_OUT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [COLOR_W-1:0] random_channel();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   // Mostly short stages so the walk keeps moving; now and then a full-range length.
   function automatic logic [LEN_W-1:0] random_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return LEN_W'($urandom_range(0, 4));
      if (pick < 95) return LEN_W'($urandom_range(0, 20));
      return LEN_W'($urandom);
   endfunction

   // Favor loads of the last entry: they restart the walk and pull it out of long stages.
   function automatic cfhs_pkg::request_type random_request();
      cfhs_pkg::request_type r;
      r.command     = ($urandom_range(0, 99) < 25) ? cfhs_pkg::CMD_WRITE : cfhs_pkg::CMD_TICK;
      r.entry_index = ($urandom_range(0, 99) < 40) ? ENTRY_IDX_W'(active_targets() - 1)
                                                   : ENTRY_IDX_W'($urandom);
      r.entry_l     = random_channel();
      r.entry_a     = random_channel();
      r.entry_b     = random_channel();
      r.fade_length = random_length();
      r.hold_length = random_length();
      return r;
   endfunction

   function automatic cfhs_pkg::request_type random_tick();
      cfhs_pkg::request_type r;
      r         = random_request();
      r.command = cfhs_pkg::CMD_TICK;
      return r;
   endfunction

   function automatic cfhs_pkg::request_type make_write(input logic [ENTRY_IDX_W-1:0] idx,
                                                        input logic signed [COLOR_W-1:0] l,
                                                        input logic signed [COLOR_W-1:0] a,
                                                        input logic signed [COLOR_W-1:0] b,
                                                        input logic [LEN_W-1:0] fade,
                                                        input logic [LEN_W-1:0] hold);
      cfhs_pkg::request_type r;
      r.command     = cfhs_pkg::CMD_WRITE;
      r.entry_index = idx;
      r.entry_l     = l;
      r.entry_a     = a;
      r.entry_b     = b;
      r.fade_length = fade;
      r.hold_length = hold;
      return r;
   endfunction

   // Offer one beat after a random gap and predict it once it is taken.
   // Valid stays high on return; a following gap or wait_for_results drops it.
   task automatic send_beat(input cfhs_pkg::request_type r);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.command;
      // five pad bits on top to fill whole bytes
      req_tdata  <= {5'b0, r.hold_length, r.fade_length, r.entry_b, r.entry_a, r.entry_l,
                     r.entry_index};
      do @(posedge clock); while (!req_tready);
      expected_colors.push_back(advance_sequencer(r));
   endtask

   // Drop valid and hold until every predicted color has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the target count over APB, then read it back. Only call with the block idle.
   task automatic program_target_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      count_setting = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("count register readback: expected %0d, got %0d", value, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Load every entry so no tick ever reads an unwritten one. With the reset count of two,
   // entry 1 is the last of the cycle: loading it snaps the color and restarts at stage 0.
   task automatic test_table_load();
      send_beat(make_write(3'd0, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'd2, 16'd1));
      send_beat(make_write(3'd1, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'd0, 16'd0));
      send_beat(make_write(3'd2, 16'sh1234, 16'shEDCB, 16'sh4000, 16'd1, 16'd0));
      send_beat(make_write(3'd3, 16'shC000, 16'sh0001, 16'sh3FFF, 16'd0, 16'd0));
      send_beat(make_write(3'd4, random_channel(), random_channel(), random_channel(),
                           16'd0, 16'd0));
      send_beat(make_write(3'd5, 16'sh2000, 16'shE000, 16'sh7FFF, 16'hFFFF, 16'hFFFF));
      send_beat(make_write(3'd6, random_channel(), random_channel(), random_channel(),
                           16'd3, 16'd1));
      send_beat(make_write(3'd7, 16'sh8000, 16'sh8000, 16'sh8000, 16'd1, 16'd2));
   endtask

   // Walk fades, holds and zero-length stages up to the fade into entry 5, whose
   // 65535-frame length exercises the widest divisor.
   task automatic test_stage_walk();
      int unsigned guard;
      wait_for_results();
      program_target_count(4'd8);
      guard = 0;
      while (stage_idx < 10 && guard < 40) begin
         send_beat(random_tick());
         guard++;
      end
      send_beat(random_tick());
      send_beat(random_tick());
   endtask

   // Lower the count below the current stage; the next tick must restart the walk.
   task automatic test_stale_stage();
      wait_for_results();
      program_target_count(4'd3);
      send_beat(random_tick());
      send_beat(random_tick());
   endtask

   // Park the color at one extreme, then open a one-frame fade across the full range from
   // the opposite extreme: the step and the sum both clip, high on L and low on a.
   task automatic test_saturation();
      wait_for_results();
      program_target_count(4'd2);
      send_beat(make_write(3'd0, 16'sh7FFF, 16'sh8000, 16'sh0010, 16'd1, 16'd0));
      send_beat(make_write(3'd2, 16'sh8000, 16'sh7FFF, 16'sh0010, 16'd1, 16'd0));
      send_beat(make_write(3'd1, 16'sh7FFF, 16'sh8000, 16'sh0010, 16'd0, 16'd0));
      wait_for_results();
      program_target_count(4'd3);
      send_beat(random_tick());
      send_beat(random_tick());
   endtask

   // Out-of-range counts: zero acts as one target, fifteen as a full table.
   task automatic test_count_limits();
      wait_for_results();
      program_target_count(4'd0);
      send_beat(random_tick());
      send_beat(random_tick());
      wait_for_results();
      program_target_count(4'd15);
      repeat (3) send_beat(random_tick());
   endtask

   // Stall the result side for a long stretch while beats keep coming, so the block backs up.
   task automatic test_backpressure();
      wait_for_results();
      program_target_count(4'd1);
      holdoff_requests++;
      repeat (24) send_beat(random_request());
   endtask

   // Random phases, each under its own target count; the extremes come first.
   task automatic test_random_phases();
      logic [COUNT_W-1:0] opening_counts [5];
      int unsigned        phase;
      opening_counts = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0};
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         if (phase < 5) begin
            program_target_count(opening_counts[phase]);
         end else if ($urandom_range(0, 9) == 0) begin
            program_target_count(COUNT_W'($urandom));
         end else begin
            program_target_count(COUNT_W'($urandom_range(1, TABLE_DEPTH)));
         end
         // some phases run with no gaps on either side
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (PHASE_BEATS) send_beat(random_request());
      end
      steady_flow = 1'b0;
   endtask

   // Result side: take each beat, compare it with the oldest prediction, then draw
   // the stall before the next one. A hold-off request overrides the draw.
   initial begin : response_checker
      int unsigned          ready_wait;
      int unsigned          holdoff_left;
      int unsigned          holds_served;
      cfhs_pkg::result_type want;
      cfhs_pkg::result_type got;
      ready_wait   = 0;
      holdoff_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.color_l       = rsp_tdata[15:0];
            got.color_a       = rsp_tdata[31:16];
            got.color_b       = rsp_tdata[47:32];
            got.color_changed = rsp_tdata[48];
            got.stage_now     = rsp_tdata[52:49];
            if (expected_colors.size() == 0) begin
               $error("color beat with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_colors.pop_front();
               check_field("color_l", want.color_l, got.color_l);
               check_field("color_a", want.color_a, got.color_a);
               check_field("color_b", want.color_b, got.color_b);
               check_field("color_changed", want.color_changed, got.color_changed);
               check_field("stage_now", want.stage_now, got.stage_now);
            end
            ready_wait = steady_flow ? 0 : $urandom_range(0, 6);
         end
         if (holdoff_requests != holds_served) begin
            holds_served++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (ready_wait != 0) begin
            ready_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: give up if the run overstays its budget.
   initial begin : cycle_watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : test_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_stage_walk();
      test_stale_stage();
      test_saturation();
      test_count_limits();
      test_backpressure();
      test_random_phases();
      wait_for_results();
      // leave room for a stray beat to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
